// ----- hdl/allc_pkg.sv -----
// Package for the ambient light lamp controller.
// Holds register codes, reset values and the state, config and result types.
// No dependencies.
package allc_pkg;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [7:0]  INDOOR_FULL  = 8'd255;
  localparam int unsigned OUTDOOR_GAIN = 7;

  typedef enum logic [2:0] {
    REG_INDOOR_LOW   = 3'd0,
    REG_INDOOR_HIGH  = 3'd1,
    REG_OUTDOOR_LOW  = 3'd2,
    REG_OUTDOOR_HIGH = 3'd3,
    REG_LEVEL_MIN    = 3'd4,
    REG_LEVEL_MAX    = 3'd5,
    REG_OFF_DELAY    = 3'd6,
    REG_LAMPS_ENABLE = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] indoor_low;
    logic [7:0] indoor_high;
    logic [7:0] outdoor_low;
    logic [7:0] outdoor_high;
    logic [7:0] level_min;
    logic [7:0] level_max;
    logic [7:0] off_delay_ticks;
    logic       lamps_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    indoor_low:      8'd0,
    indoor_high:     8'd8,
    outdoor_low:     8'd4,
    outdoor_high:    8'd20,
    level_min:       8'd5,
    level_max:       8'd40,
    off_delay_ticks: 8'd10,
    lamps_enable:    1'b1
  };

  typedef struct packed {
    logic [7:0] outdoor_level;
    logic [7:0] outdoor_countdown;
    logic       indoor_lit;
    logic [7:0] indoor_countdown;
    logic       timer_on;
  } lamp_state_t;

  typedef struct packed {
    logic        handled;
    logic        outdoor_send;
    logic [10:0] outdoor_drive;
    logic        indoor_send;
    logic [7:0]  indoor_drive;
    logic        tick_running;
  } result_t;

  function automatic logic [7:0] calc_level(input logic [7:0] s, input logic [7:0] lmin,
                                            input logic [7:0] lmax);
    logic [7:0] v;
    v = s + lmin;
    if (v < lmin) v = lmin;
    if (v > lmax) v = lmax;
    return v;
  endfunction

endpackage

// ----- hdl/allc_step.sv -----
// Next-state and result logic for one beat of the lamp controller.
// Depends on allc_pkg.
module allc_step (
  input  logic                 op,
  input  logic [7:0]           sample,
  input  allc_pkg::cfg_t       cfg,
  input  allc_pkg::lamp_state_t st,
  output allc_pkg::lamp_state_t st_nxt,
  output allc_pkg::result_t    res
);
  import allc_pkg::*;

  logic       in_indoor;
  logic       out_drop;
  logic       in_drop;
  logic [7:0] lvl_s;
  logic [7:0] ocnt_dec;
  logic [7:0] icnt_dec;
  logic       handled;
  logic       osend;
  logic       isend;
  logic [10:0] level_x8;

  assign in_indoor = (sample >= cfg.indoor_low) && (sample <= cfg.indoor_high);
  assign lvl_s     = calc_level(sample, cfg.level_min, cfg.level_max);
  assign out_drop  = ({1'b0, sample} > ({1'b0, cfg.outdoor_high} + 9'd1)) ||
                     !cfg.lamps_enable ||
                     (({1'b0, sample} + 9'd1) < {1'b0, cfg.outdoor_low});
  assign in_drop   = !in_indoor || !cfg.lamps_enable;
  assign ocnt_dec  = (st.outdoor_countdown != 8'd0) ? st.outdoor_countdown - 8'd1 : 8'd0;
  assign icnt_dec  = (st.indoor_countdown != 8'd0) ? st.indoor_countdown - 8'd1 : 8'd0;

  always_comb begin
    st_nxt  = st;
    handled = 1'b1;
    osend   = 1'b0;
    isend   = 1'b0;
    if (op == OP_CHECK) begin
      if (st.outdoor_level == 8'd0 && sample > cfg.outdoor_low &&
          sample < cfg.outdoor_high && cfg.lamps_enable) begin
        st_nxt.outdoor_level     = lvl_s;
        st_nxt.outdoor_countdown = cfg.off_delay_ticks;
        st_nxt.timer_on          = 1'b1;
        osend                    = 1'b1;
      end
      if (!st.indoor_lit && in_indoor && cfg.lamps_enable) begin
        st_nxt.indoor_lit       = 1'b1;
        st_nxt.indoor_countdown = cfg.off_delay_ticks;
        st_nxt.timer_on         = 1'b1;
        isend                   = 1'b1;
      end
    end else if (!st.timer_on) begin
      handled = 1'b0;
    end else begin
      if (out_drop) begin
        st_nxt.outdoor_countdown = ocnt_dec;
        if (ocnt_dec == 8'd0) st_nxt.outdoor_level = 8'd0;
      end else begin
        st_nxt.outdoor_countdown = cfg.off_delay_ticks;
      end
      if (in_drop) begin
        st_nxt.indoor_countdown = icnt_dec;
        if (icnt_dec == 8'd0) st_nxt.indoor_lit = 1'b0;
      end else begin
        st_nxt.indoor_countdown = cfg.off_delay_ticks;
      end
      isend = !st_nxt.indoor_lit;
      if (st_nxt.outdoor_level != 8'd0) st_nxt.outdoor_level = lvl_s;
      osend = 1'b1;
      st_nxt.timer_on = (st_nxt.outdoor_level != 8'd0) || st_nxt.indoor_lit;
    end
  end

  // drive = level * 7
  assign level_x8 = {st_nxt.outdoor_level, 3'b000};

  always_comb begin
    res.handled       = handled;
    res.outdoor_send  = osend;
    res.outdoor_drive = level_x8 - {3'b000, st_nxt.outdoor_level};
    res.indoor_send   = isend;
    res.indoor_drive  = st_nxt.indoor_lit ? INDOOR_FULL : 8'd0;
    res.tick_running  = st_nxt.timer_on;
  end

endmodule

// ----- hdl/ambient_light_lamp_controller_unit.sv -----
// Top level of the ambient light lamp controller: config registers,
// input register, lamp state and result register. Depends on allc_pkg, allc_step.
//
//   channel | direction | beat
//   in_     | sink      | operation, light_level
//   out_    | source    | handled, sends, drives, tick_running
//   cfg_    | sink      | register index, write data
//
// One beat per cycle while the receiver holds out_ready high; each beat passes through
// the input register and then the result register.
// Lamp state is updated as a beat moves from the input register to the result register.
// A stalled result holds the input register; in_ready falls only when both are full.
// Synchronous active-low reset clears config to defaults, lamp state and valids.
module ambient_light_lamp_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_light_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_handled,
  output logic        out_outdoor_send,
  output logic [10:0] out_outdoor_drive,
  output logic        out_indoor_send,
  output logic [7:0]  out_indoor_drive,
  output logic        out_tick_running,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import allc_pkg::*;

  cfg_t        cfg_r;
  lamp_state_t st_r;
  lamp_state_t st_nxt;
  result_t     res_nxt;
  result_t     res_r;
  logic        s1_valid_r;
  logic        s1_op_r;
  logic [7:0]  s1_level_r;
  logic        out_valid_r;
  logic        s1_advance;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_INDOOR_LOW:   cfg_r.indoor_low      <= cfg_data;
        REG_INDOOR_HIGH:  cfg_r.indoor_high     <= cfg_data;
        REG_OUTDOOR_LOW:  cfg_r.outdoor_low     <= cfg_data;
        REG_OUTDOOR_HIGH: cfg_r.outdoor_high    <= cfg_data;
        REG_LEVEL_MIN:    cfg_r.level_min       <= cfg_data;
        REG_LEVEL_MAX:    cfg_r.level_max       <= cfg_data;
        REG_OFF_DELAY:    cfg_r.off_delay_ticks <= cfg_data;
        REG_LAMPS_ENABLE: cfg_r.lamps_enable    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r    <= in_operation;
      s1_level_r <= in_light_level;
    end
  end

  allc_step u_step (
    .op     (s1_op_r),
    .sample (s1_level_r),
    .cfg    (cfg_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_advance) begin
        st_r <= st_nxt;
      end
      if (s1_advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_handled       = res_r.handled;
  assign out_outdoor_send  = res_r.outdoor_send;
  assign out_outdoor_drive = res_r.outdoor_drive;
  assign out_indoor_send   = res_r.indoor_send;
  assign out_indoor_drive  = res_r.indoor_drive;
  assign out_tick_running  = res_r.tick_running;

  a_stopped_lamps_off : assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.timer_on |-> (st_r.outdoor_level == 8'd0) && !st_r.indoor_lit)
    else $error("timer stopped with a lamp on");

  a_unhandled_no_send : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.handled |-> !res_r.outdoor_send && !res_r.indoor_send)
    else $error("send on an unhandled beat");

  a_stopped_drive_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.tick_running |->
      (res_r.outdoor_drive == 11'd0) && (res_r.indoor_drive == 8'd0))
    else $error("nonzero drive with tick stopped");

  a_state_tracks_result : assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance |=> res_r.tick_running == st_r.timer_on)
    else $error("result tick state differs from lamp state");

  a_stall_only_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without a full pipe");

endmodule

// ----- tb/lamp_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the ambient light lamp controller: watches the cfg, in and out
// channels, predicts every result beat and compares it field by field.
// Depends on allc_pkg.
module lamp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_light_level,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_handled,
  input  logic        out_outdoor_send,
  input  logic [10:0] out_outdoor_drive,
  input  logic        out_indoor_send,
  input  logic [7:0]  out_indoor_drive,
  input  logic        out_tick_running,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          outstanding
);
  import allc_pkg::*;

  cfg_t        reg_copy;
  lamp_state_t lamp_now;
  result_t     pending_drives[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [10:0] got,
                             input logic [10:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic logic [7:0] lit_level(input logic [7:0] s);
    logic [7:0] v;
    v = s + reg_copy.level_min;
    v = (v < reg_copy.level_min) ? reg_copy.level_min : v;
    return (v > reg_copy.level_max) ? reg_copy.level_max : v;
  endfunction

  function automatic result_t step_lamps(input logic op, input logic [7:0] s);
    result_t r;
    logic    en;
    logic    indoor_ok;
    logic    outdoor_hold;
    en        = reg_copy.lamps_enable;
    indoor_ok = (s >= reg_copy.indoor_low) && (s <= reg_copy.indoor_high);
    r         = '0;
    r.handled = 1'b1;
    if (op == OP_CHECK) begin
      if (lamp_now.outdoor_level == 8'd0 && s > reg_copy.outdoor_low &&
          s < reg_copy.outdoor_high && en) begin
        lamp_now.outdoor_level     = lit_level(s);
        lamp_now.outdoor_countdown = reg_copy.off_delay_ticks;
        lamp_now.timer_on          = 1'b1;
        r.outdoor_send             = 1'b1;
      end
      if (!lamp_now.indoor_lit && indoor_ok && en) begin
        lamp_now.indoor_lit       = 1'b1;
        lamp_now.indoor_countdown = reg_copy.off_delay_ticks;
        lamp_now.timer_on         = 1'b1;
        r.indoor_send             = 1'b1;
      end
    end else if (!lamp_now.timer_on) begin
      r.handled = 1'b0;
    end else begin
      // outdoor margin is one step wider on each side, no wrap
      outdoor_hold = en && ({1'b0, s} <= {1'b0, reg_copy.outdoor_high} + 9'd1) &&
                     ({1'b0, s} + 9'd1 >= {1'b0, reg_copy.outdoor_low});
      if (!outdoor_hold) begin
        if (lamp_now.outdoor_countdown != 8'd0) lamp_now.outdoor_countdown--;
        if (lamp_now.outdoor_countdown == 8'd0) lamp_now.outdoor_level = 8'd0;
      end else begin
        lamp_now.outdoor_countdown = reg_copy.off_delay_ticks;
      end
      if (!(indoor_ok && en)) begin
        if (lamp_now.indoor_countdown != 8'd0) lamp_now.indoor_countdown--;
        if (lamp_now.indoor_countdown == 8'd0) lamp_now.indoor_lit = 1'b0;
      end else begin
        lamp_now.indoor_countdown = reg_copy.off_delay_ticks;
      end
      r.indoor_send  = !lamp_now.indoor_lit;
      r.outdoor_send = 1'b1;
      if (lamp_now.outdoor_level != 8'd0) lamp_now.outdoor_level = lit_level(s);
      lamp_now.timer_on = (lamp_now.outdoor_level != 8'd0) || lamp_now.indoor_lit;
    end
    r.outdoor_drive = 11'(OUTDOOR_GAIN * lamp_now.outdoor_level);
    r.indoor_drive  = lamp_now.indoor_lit ? INDOOR_FULL : 8'd0;
    r.tick_running  = lamp_now.timer_on;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      reg_copy = CFG_RESET;
      lamp_now = '0;
      pending_drives.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          REG_INDOOR_LOW:   reg_copy.indoor_low      = cfg_data;
          REG_INDOOR_HIGH:  reg_copy.indoor_high     = cfg_data;
          REG_OUTDOOR_LOW:  reg_copy.outdoor_low     = cfg_data;
          REG_OUTDOOR_HIGH: reg_copy.outdoor_high    = cfg_data;
          REG_LEVEL_MIN:    reg_copy.level_min       = cfg_data;
          REG_LEVEL_MAX:    reg_copy.level_max       = cfg_data;
          REG_OFF_DELAY:    reg_copy.off_delay_ticks = cfg_data;
          REG_LAMPS_ENABLE: reg_copy.lamps_enable    = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_drives.size() == 0) begin
          report_mismatch("result beat with no prediction pending");
        end else begin
          want = pending_drives.pop_front();
          check_field("handled", 11'(out_handled), 11'(want.handled));
          check_field("outdoor_send", 11'(out_outdoor_send), 11'(want.outdoor_send));
          check_field("outdoor_drive", out_outdoor_drive, want.outdoor_drive);
          check_field("indoor_send", 11'(out_indoor_send), 11'(want.indoor_send));
          check_field("indoor_drive", 11'(out_indoor_drive), 11'(want.indoor_drive));
          check_field("tick_running", 11'(out_tick_running), 11'(want.tick_running));
        end
      end
      if (in_valid && in_ready) begin
        want = step_lamps(in_operation, in_light_level);
        pending_drives.push_back(want);
      end
      outstanding <= pending_drives.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Top of the lamp controller testbench: clock, reset, cfg writes, bursty input
// stimulus and a stalling receiver; lamp_checker does the prediction.
// Depends on allc_pkg, lamp_checker and ambient_light_lamp_controller_unit.
module tb;
  import allc_pkg::*;

  localparam int RANDOM_BEATS = 1900;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = OP_CHECK;
  logic [7:0]  in_light_level = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_handled;
  logic        out_outdoor_send;
  logic [10:0] out_outdoor_drive;
  logic        out_indoor_send;
  logic [7:0]  out_indoor_drive;
  logic        out_tick_running;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [7:0]  cfg_data = 8'd0;
  int          mismatches;
  int          outstanding;

  int burst_left = 0;
  int gap_ceiling = 6;
  int stall_left = 0;
  int stall_mode = 0;

  always #4 clk = ~clk;

  ambient_light_lamp_controller_unit dut (.*);

  lamp_checker watch (.*);

  // receiver stall pattern: the mode is redrawn at random whenever its countdown runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(40, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic beat(input logic op, input logic [7:0] lvl);
    int gap;
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_light_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, gap_ceiling);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_regs(input cfg_t c);
    logic [7:0] v;
    for (int i = 0; i < 8; i++) begin
      case (cfg_idx_t'(i))
        REG_INDOOR_LOW:   v = c.indoor_low;
        REG_INDOOR_HIGH:  v = c.indoor_high;
        REG_OUTDOOR_LOW:  v = c.outdoor_low;
        REG_OUTDOOR_HIGH: v = c.outdoor_high;
        REG_LEVEL_MIN:    v = c.level_min;
        REG_LEVEL_MAX:    v = c.level_max;
        REG_OFF_DELAY:    v = c.off_delay_ticks;
        default:          v = {7'($urandom_range(0, 127)), c.lamps_enable};
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= v;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] span_from(input logic [7:0] lo);
    int hi;
    hi = lo + $urandom_range(0, 60);
    return (hi > 255) ? 8'd255 : 8'(hi);
  endfunction

  function automatic cfg_t random_regs();
    cfg_t c;
    logic [7:0] t;
    c.indoor_low   = 8'($urandom_range(0, 255));
    c.indoor_high  = span_from(c.indoor_low);
    c.outdoor_low  = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    c.outdoor_high = ($urandom_range(0, 5) == 0) ? 8'd255 : span_from(c.outdoor_low);
    if ($urandom_range(0, 6) == 0) begin
      t = c.indoor_low;
      c.indoor_low = c.indoor_high;
      c.indoor_high = t;
    end
    if ($urandom_range(0, 6) == 0) begin
      t = c.outdoor_low;
      c.outdoor_low = c.outdoor_high;
      c.outdoor_high = t;
    end
    c.level_min = 8'($urandom_range(0, 255));
    c.level_max = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       c.off_delay_ticks = 8'd255;
      1:       c.off_delay_ticks = 8'($urandom_range(0, 255));
      default: c.off_delay_ticks = 8'($urandom_range(0, 6));
    endcase
    c.lamps_enable = ($urandom_range(0, 7) != 0);
    return c;
  endfunction

  // samples cluster on the window edges so lamps actually switch
  function automatic logic [7:0] pick_light(input cfg_t c);
    int v;
    case ($urandom_range(0, 9))
      0:       v = c.indoor_low;
      1:       v = c.indoor_high;
      2, 3:    v = c.outdoor_low;
      4, 5:    v = c.outdoor_high;
      6, 7:    v = $urandom_range(c.indoor_low, c.indoor_high);
      default: v = $urandom_range(0, 255);
    endcase
    v = v + $urandom_range(0, 6) - 3;
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
  endfunction

  initial begin
    cfg_t plan;
    int   phase;
    int   sent;
    int   seq_left;
    logic op;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset windows: tick while stopped, both turn-ons, hold margins, drops
    beat(OP_TICK, 8'd0);
    beat(OP_CHECK, 8'd0);
    beat(OP_CHECK, 8'd10);
    beat(OP_CHECK, 8'd10);
    beat(OP_TICK, 8'd21);
    beat(OP_TICK, 8'd3);
    beat(OP_TICK, 8'd22);
    beat(OP_TICK, 8'd2);
    beat(OP_TICK, 8'd255);
    settle();

    // full-span outdoor window, level wraps then clamps, zero reload delay
    plan = '{8'd255, 8'd255, 8'd0, 8'd255, 8'd200, 8'd255, 8'd0, 1'b1};
    load_regs(plan);
    beat(OP_CHECK, 8'd255);
    beat(OP_CHECK, 8'd100);
    beat(OP_TICK, 8'd0);
    beat(OP_TICK, 8'd255);
    settle();

    // inverted indoor window, zero outdoor level at turn-on
    plan = '{8'd9, 8'd3, 8'd0, 8'd255, 8'd0, 8'd0, 8'd1, 1'b1};
    load_regs(plan);
    beat(OP_CHECK, 8'd5);
    beat(OP_TICK, 8'd5);
    beat(OP_TICK, 8'd5);
    settle();

    plan = CFG_RESET;
    plan.lamps_enable = 1'b0;
    load_regs(plan);
    beat(OP_CHECK, 8'd6);
    beat(OP_TICK, 8'd6);
    settle();

    plan.lamps_enable = 1'b1;
    plan.off_delay_ticks = 8'd255;
    load_regs(plan);
    beat(OP_CHECK, 8'd6);
    beat(OP_TICK, 8'd6);
    beat(OP_TICK, 8'd6);
    settle();

    // enable dropped while both lamps are lit
    plan.lamps_enable = 1'b0;
    load_regs(plan);
    beat(OP_TICK, 8'd6);
    beat(OP_TICK, 8'd6);
    settle();

    sent = 0;
    phase = 0;
    while (sent < RANDOM_BEATS) begin
      case (phase)
        0:       plan = '0;
        1:       plan = '1;
        default: plan = random_regs();
      endcase
      load_regs(plan);
      gap_ceiling = ($urandom_range(0, 2) == 0) ? 0 : 8;
      seq_left = 0;
      for (int n = 0; n < 160; n++) begin
        if (seq_left == 0) begin
          op = OP_CHECK;
          seq_left = $urandom_range(1, 12);
        end else begin
          op = OP_TICK;
          seq_left--;
        end
        if ($urandom_range(0, 9) == 0) op = 1'($urandom_range(0, 1));
        beat(op, pick_light(plan));
        sent++;
      end
      settle();
      phase++;
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
